// File: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DSD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define DSD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/dsd_pkg.sv
`timescale 1ns / 1ps
package dsd_pkg;

	localparam logic [7:0] SEQ_TAG    = 8'h30;
	localparam logic [7:0] INT_TAG    = 8'h02;
	localparam logic [7:0] PADDED_LEN = 8'd33;
	localparam logic [7:0] HALF_LEN   = 8'd32;
	localparam logic [8:0] COUNT_MAX  = 9'd511;
	localparam logic [8:0] HEADER_MAX = 9'd257;
	localparam logic [8:0] HEADER_MIN = 9'd8;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HEADER    = 3'd1;
	localparam logic [2:0] ST_TAG       = 3'd2;
	localparam logic [2:0] ST_LENGTH    = 3'd3;
	localparam logic [2:0] ST_NEGATIVE  = 3'd4;
	localparam logic [2:0] ST_NONMIN    = 3'd5;
	localparam logic [2:0] ST_OVERSIZE  = 3'd6;
	localparam logic [2:0] ST_TRAILING  = 3'd7;

	// one finished message, handed from the parser to the output side
	typedef struct packed {
		logic       bank;
		logic [2:0] status;
		logic [4:0] start_r;
		logic [4:0] start_s;
	} desc_t;

	// byte write into the r||s store: address is {bank, half, word}
	typedef struct packed {
		logic       en;
		logic [3:0] addr;
		logic [2:0] lane;
		logic [7:0] data;
	} mem_wr_t;

	// bank handed back once its last word has been read
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

// File: rtl/dsd_front.sv
`timescale 1ns / 1ps
module dsd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       der_byte,
	input  logic             last_byte,
	input  dsd_pkg::rel_t    rel,
	output dsd_pkg::mem_wr_t wr,
	output logic             push,
	output dsd_pkg::desc_t   desc
);

	localparam logic [2:0] PH_SEQ_TAG = 3'd0;
	localparam logic [2:0] PH_SEQ_LEN = 3'd1;
	localparam logic [2:0] PH_INT_TAG = 3'd2;
	localparam logic [2:0] PH_INT_LEN = 3'd3;
	localparam logic [2:0] PH_CONTENT = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	logic [8:0] byte_count_q, byte_count_d;
	logic       first_ok_q, first_ok_d;
	logic [7:0] decl_len_q, decl_len_d;
	logic [2:0] phase_q, phase_d;
	logic       int_idx_q, int_idx_d;
	logic [7:0] int_len_q, int_len_d;
	logic [7:0] left_q, left_d;
	logic       lz_seen_q, lz_seen_d;
	logic [2:0] err_q, err_d;
	logic [4:0] start_r_q, start_r_d;
	logic [4:0] start_s_q, start_s_d;
	logic       wbank_q;
	logic [1:0] busy_q;
	logic       acc;
	logic       put;
	logic [4:0] wpos;
	logic [4:0] new_start;
	logic       hdr_fail;
	logic [2:0] status;

	assign in_ready = !busy_q[wbank_q];
	assign acc      = in_valid && in_ready;

	assign wpos      = 5'(6'd32 - left_q[5:0]);
	assign new_start = (der_byte == dsd_pkg::PADDED_LEN) ? 5'd0 :
	                   5'(6'd32 - der_byte[5:0]);

	always_comb begin
		first_ok_d = first_ok_q;
		decl_len_d = decl_len_q;
		phase_d    = phase_q;
		int_idx_d  = int_idx_q;
		int_len_d  = int_len_q;
		left_d     = left_q;
		lz_seen_d  = lz_seen_q;
		err_d      = err_q;
		start_r_d  = start_r_q;
		start_s_d  = start_s_q;
		put        = 1'b0;
		if (err_q == dsd_pkg::ST_OK) begin
			case (phase_q)
				PH_SEQ_TAG: begin
					first_ok_d = (der_byte == dsd_pkg::SEQ_TAG);
					phase_d    = PH_SEQ_LEN;
				end
				PH_SEQ_LEN: begin
					decl_len_d = der_byte;
					phase_d    = PH_INT_TAG;
				end
				PH_INT_TAG: begin
					if (byte_count_q > {1'b0, decl_len_q} || der_byte != dsd_pkg::INT_TAG) begin
						err_d = dsd_pkg::ST_TAG;
					end else begin
						phase_d = PH_INT_LEN;
					end
				end
				PH_INT_LEN: begin
					if (der_byte == 8'd0 ||
					    {1'b0, byte_count_q} + {2'b00, der_byte} >
					    {2'b00, decl_len_q} + 10'd1) begin
						err_d = dsd_pkg::ST_LENGTH;
					end else begin
						int_len_d = der_byte;
						left_d    = der_byte;
						lz_seen_d = 1'b0;
						phase_d   = PH_CONTENT;
						if (int_idx_q) begin
							start_s_d = new_start;
						end else begin
							start_r_d = new_start;
						end
					end
				end
				PH_CONTENT: begin
					if (left_q == int_len_q) begin
						// leading byte: sign, padding and size checks
						if (der_byte[7]) begin
							err_d = dsd_pkg::ST_NEGATIVE;
						end else if (der_byte == 8'd0 && int_len_q == dsd_pkg::PADDED_LEN) begin
							lz_seen_d = 1'b1;
						end else if (der_byte == 8'd0 && int_len_q > 8'd1) begin
							err_d = dsd_pkg::ST_NONMIN;
						end else if (int_len_q > dsd_pkg::HALF_LEN) begin
							err_d = dsd_pkg::ST_OVERSIZE;
						end else begin
							put = 1'b1;
						end
					end else if (lz_seen_q && !der_byte[7]) begin
						err_d = dsd_pkg::ST_NONMIN;
					end else begin
						lz_seen_d = 1'b0;
						put       = 1'b1;
					end
					if (err_d == dsd_pkg::ST_OK) begin
						left_d = left_q - 8'd1;
						if (left_q == 8'd1) begin
							if (!int_idx_q) begin
								int_idx_d = 1'b1;
								phase_d   = PH_INT_TAG;
							end else begin
								phase_d = PH_DONE;
							end
						end
					end
				end
				default: begin
					err_d = dsd_pkg::ST_TRAILING;
				end
			endcase
		end
	end

	// bytes beyond a 32-byte window are never stored
	assign wr.en   = acc && put && (left_q <= dsd_pkg::HALF_LEN);
	assign wr.addr = {wbank_q, int_idx_q, wpos[4:3]};
	assign wr.lane = wpos[2:0];
	assign wr.data = der_byte;

	assign byte_count_d = (byte_count_q == dsd_pkg::COUNT_MAX) ? byte_count_q :
	                      byte_count_q + 9'd1;

	assign hdr_fail = byte_count_d < dsd_pkg::HEADER_MIN || byte_count_d > dsd_pkg::HEADER_MAX ||
	                  !first_ok_d || {1'b0, decl_len_d} != byte_count_d - 9'd2;

	always_comb begin
		if (hdr_fail) begin
			status = dsd_pkg::ST_HEADER;
		end else if (err_d != dsd_pkg::ST_OK) begin
			status = err_d;
		end else if (phase_d == PH_DONE) begin
			status = dsd_pkg::ST_OK;
		end else if (phase_d == PH_CONTENT) begin
			status = dsd_pkg::ST_LENGTH;
		end else begin
			status = dsd_pkg::ST_TAG;
		end
	end

	assign push         = acc && last_byte;
	assign desc.bank    = wbank_q;
	assign desc.status  = status;
	assign desc.start_r = start_r_d;
	assign desc.start_s = start_s_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			first_ok_q   <= 1'b0;
			decl_len_q   <= '0;
			phase_q      <= PH_SEQ_TAG;
			int_idx_q    <= 1'b0;
			int_len_q    <= '0;
			left_q       <= '0;
			lz_seen_q    <= 1'b0;
			err_q        <= dsd_pkg::ST_OK;
			start_r_q    <= '0;
			start_s_q    <= '0;
			wbank_q      <= 1'b0;
		end else if (acc) begin
			if (last_byte) begin
				byte_count_q <= '0;
				first_ok_q   <= 1'b0;
				decl_len_q   <= '0;
				phase_q      <= PH_SEQ_TAG;
				int_idx_q    <= 1'b0;
				int_len_q    <= '0;
				left_q       <= '0;
				lz_seen_q    <= 1'b0;
				err_q        <= dsd_pkg::ST_OK;
				start_r_q    <= '0;
				start_s_q    <= '0;
				wbank_q      <= !wbank_q;
			end else begin
				byte_count_q <= byte_count_d;
				first_ok_q   <= first_ok_d;
				decl_len_q   <= decl_len_d;
				phase_q      <= phase_d;
				int_idx_q    <= int_idx_d;
				int_len_q    <= int_len_d;
				left_q       <= left_d;
				lz_seen_q    <= lz_seen_d;
				err_q        <= err_d;
				start_r_q    <= start_r_d;
				start_s_q    <= start_s_d;
			end
		end
	end

	// hold a bank from message end until its last word is read out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int i = 0; i < 2; i++) begin
				if (push && wbank_q == 1'(i)) begin
					busy_q[i] <= 1'b1;
				end else if (rel.valid && rel.bank == 1'(i)) begin
					busy_q[i] <= 1'b0;
				end
			end
		end
	end

endmodule

// File: rtl/dsd_queue.sv
`timescale 1ns / 1ps
module dsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dsd_pkg::desc_t push_desc,
	input  logic           pop,
	output logic           head_valid,
	output dsd_pkg::desc_t head_desc,
	output logic           full
);

	dsd_pkg::desc_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign head_valid = (count_q != 2'd0);
	assign full       = (count_q == 2'd2);
	assign head_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/dsd_back.sv
`timescale 1ns / 1ps
module dsd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dsd_pkg::mem_wr_t wr,
	input  logic             head_valid,
	input  dsd_pkg::desc_t   head_desc,
	output logic             pop,
	output dsd_pkg::rel_t    rel,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       word_index,
	output logic [63:0]      raw_word,
	output logic [2:0]       status,
	output logic             last_result
);

	logic [63:0]    mem_q [16];
	logic [63:0]    rdata_q;
	logic [2:0]     word_q;
	logic           issue;
	logic           last_item;
	logic           valid_s1;
	logic [2:0]     word_s1;
	dsd_pkg::desc_t desc_s1;
	logic           last_s1;
	logic           move_s1;
	logic [63:0]    masked;
	logic [4:0]     start;
	logic           out_valid_q;
	logic [2:0]     word_index_q;
	logic [63:0]    raw_word_q;
	logic [2:0]     status_q;
	logic           last_result_q;

	// two banks of eight 64-bit words, byte-lane writes
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr][{~wr.lane, 3'b000} +: 8] <= wr.data;
		end
		if (issue) begin
			rdata_q <= mem_q[{head_desc.bank, word_q}];
		end
	end

	assign move_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign issue     = head_valid && (!valid_s1 || move_s1);
	assign last_item = (head_desc.status != dsd_pkg::ST_OK) || (word_q == 3'd7);
	assign pop       = issue && last_item;
	assign rel.valid = pop;
	assign rel.bank  = head_desc.bank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (issue) begin
				word_q <= last_item ? 3'd0 : word_q + 3'd1;
			end
			valid_s1 <= issue || (valid_s1 && !move_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			word_s1 <= word_q;
			desc_s1 <= head_desc;
			last_s1 <= last_item;
		end
	end

	// bytes ahead of an integer's first stored byte were never written: read as zero
	assign start = word_s1[2] ? desc_s1.start_s : desc_s1.start_r;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (desc_s1.status == dsd_pkg::ST_OK && {word_s1[1:0], 3'(i)} >= start) begin
				masked[63 - 8 * i -: 8] = rdata_q[63 - 8 * i -: 8];
			end else begin
				masked[63 - 8 * i -: 8] = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			word_index_q  <= (desc_s1.status == dsd_pkg::ST_OK) ? word_s1 : 3'd0;
			raw_word_q    <= masked;
			status_q      <= desc_s1.status;
			last_result_q <= last_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign word_index  = word_index_q;
	assign raw_word    = raw_word_q;
	assign status      = status_q;
	assign last_result = last_result_q;

endmodule

// File: rtl/der_signature_decoder.sv
`timescale 1ns / 1ps
// Throughput: one DER byte per cycle in, one 64-bit result per cycle out.
// Results go from the queue through the read and output registers;
// an ok message then gives 8 words on consecutive cycles while out_ready is high.
// Input stalls only while both store banks wait for the output side to read them.
// Reset: arst_n asynchronous, active low; clears parser, queue and output valid.
`include "assert_macros.svh"
module der_signature_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  der_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  word_index,
	output logic [63:0] raw_word,
	output logic [2:0]  status,
	output logic        last_result
);

	// Front: parse one byte per transaction, write integer bytes into the
	// current bank and push a descriptor when the final byte arrives.
	dsd_pkg::mem_wr_t wr;
	dsd_pkg::rel_t    rel;
	dsd_pkg::desc_t   push_desc;
	dsd_pkg::desc_t   head_desc;
	logic             push;
	logic             pop;
	logic             head_valid;
	logic             q_full;

	dsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.der_byte  (der_byte),
		.last_byte (last_byte),
		.rel       (rel),
		.wr        (wr),
		.push      (push),
		.desc      (push_desc)
	);

	// Two-entry descriptor queue: one per store bank, so it cannot overflow.
	dsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.full       (q_full)
	);

	// Back: read one bank word per cycle unless stalled, mask never-written
	// leading bytes, drive the output register; release the bank on its last read.
	dsd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.head_valid  (head_valid),
		.head_desc   (head_desc),
		.pop         (pop),
		.rel         (rel),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.word_index  (word_index),
		.raw_word    (raw_word),
		.status      (status),
		.last_result (last_result)
	);

	// A message end never finds both banks' descriptors still queued.
	`DSD_ASSERT_IMP(a_push_not_full, push, !q_full)
	// A pushed descriptor is visible at the queue head next cycle.
	`DSD_ASSERT_NXT(a_push_visible, push, head_valid)
	// Error results are a single zero word.
	`DSD_ASSERT_IMP(a_err_shape, out_valid && status != dsd_pkg::ST_OK,
		raw_word == 64'd0 && last_result && word_index == 3'd0)
	// An ok message ends on word seven.
	`DSD_ASSERT_IMP(a_ok_last, out_valid && status == dsd_pkg::ST_OK && last_result,
		word_index == 3'd7)

endmodule

// File: tb/tb_der_signature_decoder.sv
`timescale 1ns / 1ps
module tb_der_signature_decoder;

	// Run bounds: random bytes across all idle mixes, and the watchdog.
	localparam int RANDOM_BYTES = 120;
	localparam int MIN_WORDS    = 12;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [2:0] {
		PH_SEQ_TAG, PH_SEQ_LEN, PH_INT_TAG, PH_INT_LEN, PH_CONTENT, PH_DONE
	} der_phase_t;

	// One output transaction as the block should present it.
	typedef struct packed {
		logic [2:0]  word_index;
		logic [63:0] raw_word;
		logic [2:0]  status;
		logic        last_result;
	} sig_word_t;

	// Mirror of the DER parser. Every accepted byte advances the mirror; the final
	// byte of a signature turns into eight r||s words or one error word, queued
	// in order and matched against what comes out of the block.
	class sig_scoreboard;
		int         byte_count;
		bit         seq_tag_ok;
		int         seq_len;
		der_phase_t phase;
		bit         in_s;
		int         int_len;
		int         left;
		bit         pad_zero;
		logic [2:0] err;
		logic [7:0] rs_bytes[64];
		sig_word_t  pending[$];
		int         errors;
		int         words_expected;
		int         words_seen;
		int         signatures;
		int         good_signatures;

		function new();
			clear();
		endfunction

		// Back to the idle parser state with an all-zero r||s store.
		function void clear();
			byte_count = 0;
			seq_tag_ok = 0;
			seq_len    = 0;
			phase      = PH_SEQ_TAG;
			in_s       = 0;
			int_len    = 0;
			left       = 0;
			pad_zero   = 0;
			err        = dsd_pkg::ST_OK;
			foreach (rs_bytes[i]) rs_bytes[i] = 8'h00;
		endfunction

		// Queue one expected result at the tail.
		function void expect_word(sig_word_t e);
			pending.insert(pending.size(), e);
			words_expected++;
		endfunction

		// Right-align the integer in its 32-byte half; bytes beyond 32 are dropped.
		function void store_byte(logic [7:0] b);
			int p;
			p = int'(in_s) * int'(dsd_pkg::HALF_LEN) + int'(dsd_pkg::HALF_LEN) - left;
			if (left >= 1 && left <= int'(dsd_pkg::HALF_LEN)) rs_bytes[p & 63] = b;
		endfunction

		function void take_content(logic [7:0] b);
			if (left == int_len) begin
				if (b[7]) begin
					err = dsd_pkg::ST_NEGATIVE;
					return;
				end
				if (b == 8'h00 && int_len == int'(dsd_pkg::PADDED_LEN)) begin
					pad_zero = 1;
				end else if (b == 8'h00 && int_len > 1) begin
					err = dsd_pkg::ST_NONMIN;
					return;
				end else if (int_len > int'(dsd_pkg::HALF_LEN)) begin
					err = dsd_pkg::ST_OVERSIZE;
					return;
				end else begin
					store_byte(b);
				end
			end else begin
				// a padding zero is only legal in front of a set sign bit
				if (pad_zero) begin
					if (!b[7]) begin
						err = dsd_pkg::ST_NONMIN;
						return;
					end
					pad_zero = 0;
				end
				store_byte(b);
			end
			left = (left - 1) & 8'hff;
			if (left == 0) begin
				if (!in_s) begin
					in_s  = 1;
					phase = PH_INT_TAG;
				end else begin
					phase = PH_DONE;
				end
			end
		endfunction

		function void parse(logic [7:0] b, int pos);
			case (phase)
				PH_SEQ_TAG: begin
					seq_tag_ok = (b == dsd_pkg::SEQ_TAG);
					phase      = PH_SEQ_LEN;
				end
				PH_SEQ_LEN: begin
					seq_len = b;
					phase   = PH_INT_TAG;
				end
				PH_INT_TAG: begin
					if (pos > seq_len || b != dsd_pkg::INT_TAG) err = dsd_pkg::ST_TAG;
					else phase = PH_INT_LEN;
				end
				PH_INT_LEN: begin
					if (b == 8'h00 || pos + 1 + int'(b) > seq_len + 2) begin
						err = dsd_pkg::ST_LENGTH;
					end else begin
						int_len  = b;
						left     = b;
						pad_zero = 0;
						phase    = PH_CONTENT;
					end
				end
				PH_CONTENT: take_content(b);
				default: err = dsd_pkg::ST_TRAILING;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			int          pos;
			logic [2:0]  st;
			logic [63:0] w;
			pos = byte_count;
			if (err == dsd_pkg::ST_OK) parse(b, pos);
			if (byte_count < int'(dsd_pkg::COUNT_MAX)) byte_count++;
			if (!fin) return;
			signatures++;
			if (byte_count < int'(dsd_pkg::HEADER_MIN) ||
					byte_count > int'(dsd_pkg::HEADER_MAX) ||
					!seq_tag_ok || seq_len != byte_count - 2)
				st = dsd_pkg::ST_HEADER;
			else if (err != dsd_pkg::ST_OK)
				st = err;
			else if (phase == PH_DONE)
				st = dsd_pkg::ST_OK;
			else if (phase == PH_CONTENT)
				st = dsd_pkg::ST_LENGTH;
			else
				st = dsd_pkg::ST_TAG;
			if (st != dsd_pkg::ST_OK) begin
				expect_word('{3'd0, 64'd0, st, 1'b1});
			end else begin
				good_signatures++;
				for (int k = 0; k < 8; k++) begin
					w = '0;
					for (int i = 0; i < 8; i++) w = {w[55:0], rs_bytes[k * 8 + i]};
					expect_word('{3'(k), w, dsd_pkg::ST_OK, k == 7});
				end
			end
			clear();
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_word(logic [2:0] idx, logic [63:0] word, logic [2:0] st,
				logic fin);
			sig_word_t e;
			words_seen++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, %s idx=%0d word=%h st=%0d last=%0b",
					$time, "actual", idx, word, st, fin);
				return;
			end
			e = pending.pop_front();
			field_check("word_index", e.word_index, idx);
			field_check("raw_word", e.raw_word, word);
			field_check("status", e.status, st);
			field_check("last_result", e.last_result, fin);
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  der_byte  = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  word_index;
	logic [63:0] raw_word;
	logic [2:0]  status;
	logic        last_result;

	sig_scoreboard sb = new();

	int idle_pct    = 0;
	int stall_pct   = 0;
	int bytes_sent  = 0;
	int cycle_count = 0;

	der_signature_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.der_byte   (der_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_index (word_index),
		.raw_word   (raw_word),
		.status     (status),
		.last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Sample both channels at the rising edge. Results of this edge always belong
	// to bytes taken at earlier edges, so check before noting the new byte.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_word(word_index, raw_word, status, last_result);
			if (in_valid && in_ready) sb.note_byte(der_byte, last_byte);
		end
	end

	// Stall the result channel at random, changing ready only at the falling edge.
	always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

	// Drive one byte: idle at random first, then hold valid and payload until taken.
	task automatic push_byte(logic [7:0] b, logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		der_byte  <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_sig(byte_q_t m);
		foreach (m[i]) push_byte(m[i], i == m.size() - 1);
	endtask

	// Hold the sender off until every expected word is out, then let the pipe settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic byte_q_t fill(int n, logic [7:0] head, logic [7:0] tail);
		byte_q_t q;
		q.insert(q.size(), head);
		repeat (n - 1) q.insert(q.size(), tail);
		return q;
	endfunction

	// Minimal non-negative integer body of n bytes; 33 bytes means a padding zero.
	function automatic byte_q_t valid_int(int n);
		byte_q_t q;
		repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
		if (n == 33) begin
			q[0]    = 8'h00;
			q[1][7] = 1'b1;
		end else if (n == 1) begin
			q[0][7] = 1'b0;
		end else begin
			q[0] = 8'($urandom_range(1, 127));
		end
		return q;
	endfunction

	// Mostly short integers, with a fair share of full-size and padded ones.
	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 15) return 33;
		if (r < 25) return 32;
		return $urandom_range(1, 8);
	endfunction

	// SEQUENCE { INTEGER r, INTEGER s } with a matching outer length.
	function automatic byte_q_t wrap(byte_q_t r, byte_q_t s);
		byte_q_t m;
		m = {dsd_pkg::SEQ_TAG, 8'h00, dsd_pkg::INT_TAG, 8'(r.size())};
		m = {m, r, dsd_pkg::INT_TAG, 8'(s.size()), s};
		m[1] = 8'(m.size() - 2);
		return m;
	endfunction

	// Well-formed signature with random content, or one broken in a random way.
	function automatic byte_q_t random_sig();
		byte_q_t m;
		byte_q_t r;
		int      kind;
		int      n;
		m = wrap(valid_int(pick_len()), valid_int(pick_len()));
		if ($urandom_range(99) < 70) return m;
		kind = $urandom_range(0, 9);
		case (kind)
			0: begin
				n = $urandom_range(0, m.size() - 1);
				m[n] ^= 8'(1 << $urandom_range(0, 7));
			end
			1: begin
				n = $urandom_range(1, m.size() - 1);
				m = m[0:n-1];
			end
			2: repeat ($urandom_range(1, 3)) m.insert(m.size(), 8'($urandom_range(0, 255)));
			3: m[4][7] = 1'b1;
			4: begin
				if (m[3] == dsd_pkg::PADDED_LEN) m[5][7] = 1'b0;
				else m[4] = 8'h00;
			end
			5: begin
				n = $urandom_range(33, 40);
				repeat (n) r.insert(r.size(), 8'($urandom_range(0, 255)));
				r[0] = 8'($urandom_range(1, 127));
				m = wrap(r, valid_int(pick_len()));
			end
			6: m[3] = 8'h00;
			7: begin
				m.delete();
				repeat ($urandom_range(1, 12)) m.insert(m.size(), 8'($urandom_range(0, 255)));
			end
			8: m[3] = m[3] + 8'($urandom_range(1, 4));
			default: m[1] = 8'($urandom_range(0, 255));
		endcase
		// repair the outer length half the time so the inner checks decide
		if ((kind <= 2 || kind == 8) && m.size() >= 2 && $urandom_range(1))
			m[1] = 8'(m.size() - 2);
		return m;
	endfunction

	initial begin : stimulus
		byte_q_t m;
		int      send_idle[4]  = '{0, 49, 0, 26};
		int      recv_stall[4] = '{0, 0, 49, 26};
		int      byte_mark;
		int      word_mark;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed signatures: extremes of r and s, then one of each failure.
		send_sig(wrap(fill(1, 8'h00, 8'h00), fill(1, 8'h7f, 8'h7f)));
		send_sig(wrap(fill(33, 8'h00, 8'hff), fill(32, 8'h7f, 8'hff)));
		send_sig(wrap(fill(33, 8'h00, 8'h80), fill(2, 8'h01, 8'h00)));
		m = wrap(fill(1, 8'h00, 8'h00), fill(1, 8'h7f, 8'h7f));
		m[0] = 8'h31;
		send_sig(m);                                        // bad SEQUENCE tag
		m = m[0:4];
		m[0] = dsd_pkg::SEQ_TAG;
		send_sig(m);                                        // too short
		m = wrap(fill(1, 8'h05, 8'h05), fill(1, 8'h06, 8'h06));
		m[2] = 8'h03;
		send_sig(m);                                        // bad INTEGER tag for r
		m[2] = dsd_pkg::INT_TAG;
		m[5] = 8'h04;
		send_sig(m);                                        // bad INTEGER tag for s
		m = wrap(fill(4, 8'h01, 8'h02), fill(1, 8'h01, 8'h01));
		m = m[0:7];
		m[1] = 8'd6;
		send_sig(m);                                        // ends before the s header
		m = wrap(fill(1, 8'h05, 8'h05), fill(5, 8'h01, 8'h02));
		m = m[0:7];
		m[1] = 8'd6;
		send_sig(m);                                        // s longer than the message
		m = wrap(fill(1, 8'h05, 8'h05), fill(1, 8'h06, 8'h06));
		m[3] = 8'h00;
		send_sig(m);                                        // zero-length integer
		send_sig(wrap(fill(1, 8'h80, 8'h80), fill(1, 8'h01, 8'h01)));  // negative
		send_sig(wrap(fill(2, 8'h00, 8'h01), fill(1, 8'h01, 8'h01)));  // leading zero
		send_sig(wrap(fill(33, 8'h00, 8'h7f), fill(1, 8'h01, 8'h01))); // needless pad
		send_sig(wrap(fill(33, 8'h01, 8'h00), fill(1, 8'h01, 8'h01))); // 33 bytes, no pad
		send_sig(wrap(fill(34, 8'h7f, 8'hff), fill(1, 8'h01, 8'h01))); // 34 bytes
		m = wrap(fill(1, 8'h00, 8'h00), fill(1, 8'h7f, 8'h7f));
		m.insert(m.size(), 8'h00);
		send_sig(m);                                        // trailing byte, bad length
		m[1] = 8'(m.size() - 2);
		send_sig(m);                                        // trailing byte, length fits
		send_sig(fill(1, dsd_pkg::SEQ_TAG, dsd_pkg::SEQ_TAG));  // single-byte message
		drain();

		// Random signatures under each idle mix; pause for a full drain between mixes.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = send_idle[ph];
			stall_pct = recv_stall[ph];
			byte_mark = bytes_sent;
			word_mark = sb.words_expected;
			while (bytes_sent - byte_mark < RANDOM_BYTES / 4 ||
					sb.words_expected - word_mark < MIN_WORDS)
				send_sig(random_sig());
			drain();
		end

		$display("Covered %0d signatures (%0d well formed), %0d bytes in, %0d result words out,",
			sb.signatures, sb.good_signatures, bytes_sent, sb.words_seen);
		$display("with no idling, sender gaps, receiver stalls and both together.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[der_signature_decoder] OK");
		else
			$display("[der_signature_decoder] ERROR");
		$finish;
	end

	// Watchdog: give up if the run hangs.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timed out with %0d result words still expected", $time,
			sb.pending.size());
		$display("[der_signature_decoder] ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/dsd_pkg.sv
rtl/dsd_front.sv
rtl/dsd_queue.sv
rtl/dsd_back.sv
rtl/der_signature_decoder.sv
tb/tb_der_signature_decoder.sv
